>>> hdl/ahbs_pkg.sv
// Shared types and constants of the approximate histogram best-split unit.
package ahbs_pkg;

    localparam int LEVEL_CAP      = 8;
    localparam int DEF_MAX_LEVELS = 8;
    localparam int DEF_MAX_KEPT   = 64;
    localparam int DEF_MAX_ITEMS  = 65536;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVELS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_FRACTION = 2'd1;

    localparam logic [3:0]  MAX_LEVELS_RST = 4'd5;
    localparam logic [15:0] EPS_RST        = 16'd6554;

    localparam int SUM_W = 48;
    localparam int SQ_W  = 63;
    localparam int PTS_W = 33;
    localparam int ERR_W = 64;

    typedef struct packed {
        logic signed [15:0] value;
        logic [15:0]        weight;
        logic               final_item;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  best_count;
        logic [16:0] variance_drop;
        logic [15:0] bucket_start;
        logic        start_valid;
        logic        list_overflow;
        logic        run_end;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [PTS_W-1:0] pts;
    } err_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ERR_W-1:0] err;
    } err_rsp_t;

endpackage

>>> hdl/ahbs_err_unit.sv
// Run error unit: sq - floor(sum^2 / pts), 24-bit partial products, bit-serial divide.
module ahbs_err_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  ahbs_pkg::err_req_t req,
    output ahbs_pkg::err_rsp_t rsp
);
    import ahbs_pkg::*;

    typedef enum logic [2:0] {E_IDLE, E_MUL, E_CHK, E_DIV, E_FIN} estate_t;

    estate_t          state_reg;
    logic [1:0]       step_reg;
    logic [5:0]       cnt_reg;
    logic [47:0]      mag_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [PTS_W-1:0] pts_reg;
    logic [95:0]      acc_reg;
    logic [PTS_W-1:0] rem_reg;
    logic             done_reg;
    logic [ERR_W-1:0] err_reg;

    logic [47:0]      mag_in;
    logic [23:0]      mul_x, mul_y;
    logic [47:0]      pp;
    logic [PTS_W:0]   rt;
    logic             ge;
    logic [ERR_W:0]   sq_ext;

    assign mag_in = req.sum[SUM_W-1] ? (48'd0 - req.sum) : req.sum;

    always_comb begin
        mul_x = mag_reg[23:0];
        mul_y = mag_reg[23:0];
        case (step_reg)
            2'd1:    mul_x = mag_reg[47:24];
            2'd2: begin
                mul_x = mag_reg[47:24];
                mul_y = mag_reg[47:24];
            end
            default: mul_x = mag_reg[23:0];
        endcase
        pp = mul_x * mul_y;
        rt = {rem_reg, acc_reg[63]};
        ge = rt >= {1'b0, pts_reg};
        sq_ext = {2'b0, sq_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE: begin
                    if (req.start) begin
                        mag_reg  <= mag_in;
                        sq_reg   <= req.sq;
                        pts_reg  <= req.pts;
                        step_reg <= 2'd0;
                        if (req.pts == '0) begin
                            acc_reg   <= '0;
                            state_reg <= E_FIN;
                        end else begin
                            state_reg <= E_MUL;
                        end
                    end
                end
                E_MUL: begin
                    // a0*a0 + 2*a1*a0<<24 + a1*a1<<48
                    case (step_reg)
                        2'd0:    acc_reg <= 96'(pp);
                        2'd1:    acc_reg <= acc_reg + (96'(pp) << 25);
                        default: acc_reg <= acc_reg + (96'(pp) << 48);
                    endcase
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2) state_reg <= E_CHK;
                end
                E_CHK: begin
                    if ({1'b0, acc_reg[95:64]} >= pts_reg) begin
                        acc_reg[63:0] <= '1;   // quotient saturates
                        state_reg     <= E_FIN;
                    end else begin
                        rem_reg   <= {1'b0, acc_reg[95:64]};
                        cnt_reg   <= '0;
                        state_reg <= E_DIV;
                    end
                end
                E_DIV: begin
                    rem_reg       <= ge ? PTS_W'(rt - {1'b0, pts_reg}) : rt[PTS_W-1:0];
                    acc_reg[63:0] <= {acc_reg[62:0], ge};
                    cnt_reg       <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) state_reg <= E_FIN;
                end
                E_FIN: begin
                    err_reg   <= (sq_ext > {1'b0, acc_reg[63:0]})
                                 ? ERR_W'(sq_ext - {1'b0, acc_reg[63:0]}) : '0;
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign rsp.busy = (state_reg != E_IDLE);
    assign rsp.done = done_reg;
    assign rsp.err  = err_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done) else $error("done held longer than one cycle");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.start && !rsp.busy) |=> rsp.busy) else $error("start not taken");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> !rsp.busy) else $error("done while busy");

endmodule

>>> hdl/approx_histogram_best_split_unit.sv
// Top level of the approximate histogram best-split unit.
// Takes one weighted value per beat and keeps, per level, a list of split points in one
// synchronous memory of MAX_LEVELS x 2^ceil(log2(MAX_KEPT)) entries.
// Per item, the kept entries of each level below are walked through the single shared run
// error unit, whose divider makes one quotient bit a cycle. An item marked final is then
// backtracked through the levels before its result beats, one to eight of them, go out; no
// input is taken until the last is delivered. Memory entries need no clearing after reset:
// only slots below each level's fill count are ever read.
module approx_histogram_best_split_unit #(
    parameter int MAX_LEVELS = ahbs_pkg::DEF_MAX_LEVELS,
    parameter int MAX_KEPT   = ahbs_pkg::DEF_MAX_KEPT,
    parameter int MAX_ITEMS  = ahbs_pkg::DEF_MAX_ITEMS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ahbs_pkg::in_item_t           s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ahbs_pkg::out_item_t          m_item,
    input  logic                         cfg_we,
    input  logic [ahbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ahbs_pkg::*;

    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int LVL_W     = $clog2(MAX_LEVELS);
    localparam int KCNT_W    = $clog2(MAX_LEVELS + 1);
    localparam int KEPT_W    = $clog2(MAX_KEPT);
    localparam int FILL_W    = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W    = LVL_W + KEPT_W;
    localparam int MEM_DEPTH = MAX_LEVELS * (2 ** KEPT_W);
    localparam int LV_CAP    = (MAX_LEVELS < LEVEL_CAP) ? MAX_LEVELS : LEVEL_CAP;
    localparam int ST_W      = $clog2(LEVEL_CAP);

    typedef struct packed {
        logic [IDX_W-1:0] key;
        logic [IDX_W:0]   start;
        logic [ERR_W-1:0] err;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [PTS_W-1:0] pts;
    } kept_t;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_ACC, S_LVL, S_EWAIT, S_RD, S_RDW, S_SEG, S_JUDGE,
        S_THR0, S_THR1, S_THR2, S_WR, S_BEST, S_DSET, S_DROP, S_BTL, S_BTR,
        S_BTC, S_EMIT
    } state_t;

    // kept-point memory
    kept_t             mem [MEM_DEPTH];
    kept_t             rdata_reg, wdata;
    logic [ADDR_W-1:0] raddr, waddr;
    logic              we;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    state_t               state_reg;
    logic [3:0]           max_levels_reg;
    logic [15:0]          eps_reg;
    logic [SUM_W-1:0]     run_sum_reg;
    logic [SQ_W-1:0]      run_sq_reg;
    logic [PTS_W-1:0]     run_pts_reg;
    logic [IDX_W-1:0]     item_idx_reg, cur_key_reg;
    logic signed [15:0]   value_reg;
    logic [15:0]          weight_reg;
    logic                 final_reg;
    logic signed [32:0]   prod_reg;
    logic [31:0]          vsq_reg;
    logic [ERR_W-1:0]     lvl_err_reg [MAX_LEVELS];
    logic [ERR_W-1:0]     thr_reg     [MAX_LEVELS];
    logic                 thr_set_reg [MAX_LEVELS];
    logic [FILL_W-1:0]    fill_reg    [MAX_LEVELS];
    logic                 ovf_reg;
    logic [KCNT_W-1:0]    k_reg, i_reg, lev_reg;
    logic [FILL_W-1:0]    walk_reg, prev_fill_reg, bt_fill_reg;
    logic [ERR_W-1:0]     prev_err_reg, best_e_reg, top_reg, r_reg;
    logic [IDX_W:0]       best_start_reg;
    logic                 accept_reg;
    logic [48:0]          plo_reg, phi_reg;
    logic [3:0]           best_cnt_reg, nb_reg, out_idx_reg;
    logic [16:0]          drop_reg;
    logic [3:0]           dcnt_reg;
    logic signed [IDX_W+1:0] end_reg;
    logic [IDX_W:0]       starts_reg [LEVEL_CAP];

    err_req_t err_req;
    err_rsp_t err_rsp;

    ahbs_err_unit u_err (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (err_req),
        .rsp     (err_rsp)
    );

    logic [3:0]           lv;
    logic [LVL_W-1:0]     kidx, kprev, iidx, levidx;
    logic [FILL_W-1:0]    fill_k, new_fill;
    logic [KEPT_W-1:0]    slot;
    logic                 slot_ovf;
    logic [16:0]          eps_mult;
    logic [80:0]          thr_full;
    logic [ERR_W:0]       seg_sum;
    logic [ERR_W-1:0]     seg_t, red, dsub;
    logic [IDX_W+1:0]     st_end;
    logic                 is_last_lvl;
    logic [IDX_W-1:0]     next_idx;
    logic [3:0]           n_out, sel;
    logic [IDX_W+16:0]    st_ext;

    always_comb begin
        if (max_levels_reg < 4'd2)               lv = 4'd2;
        else if (32'(max_levels_reg) > LV_CAP)   lv = 4'(LV_CAP);
        else                                     lv = max_levels_reg;

        kidx   = k_reg[LVL_W-1:0];
        kprev  = LVL_W'(k_reg - KCNT_W'(1));
        iidx   = i_reg[LVL_W-1:0];
        levidx = lev_reg[LVL_W-1:0];

        fill_k   = fill_reg[kidx];
        slot_ovf = 1'b0;
        if (!accept_reg && fill_k != '0) begin
            slot     = KEPT_W'(fill_k - FILL_W'(1));
            new_fill = fill_k;
        end else if (fill_k < FILL_W'(MAX_KEPT)) begin
            slot     = KEPT_W'(fill_k);
            new_fill = fill_k + FILL_W'(1);
        end else begin
            slot     = KEPT_W'(MAX_KEPT - 1);
            new_fill = fill_k;
            slot_ovf = (32'(k_reg) < 32'(lv));
        end

        we          = (state_reg == S_WR);
        waddr       = {kidx, slot};
        wdata.key   = cur_key_reg;
        wdata.start = best_start_reg;
        wdata.err   = best_e_reg;
        wdata.sum   = run_sum_reg;
        wdata.sq    = run_sq_reg;
        wdata.pts   = run_pts_reg;

        if (state_reg == S_BTR) raddr = {levidx, walk_reg[KEPT_W-1:0]};
        else                    raddr = {kprev, walk_reg[KEPT_W-1:0]};

        // segment from a kept point of the level below (at level 0, from the run start) to the current item
        err_req.start = 1'b0;
        err_req.sum   = run_sum_reg - rdata_reg.sum;
        err_req.sq    = run_sq_reg - rdata_reg.sq;
        err_req.pts   = run_pts_reg - rdata_reg.pts;
        if (state_reg == S_LVL && k_reg == '0) begin
            err_req.start = 1'b1;
            err_req.sum   = run_sum_reg;
            err_req.sq    = run_sq_reg;
            err_req.pts   = run_pts_reg;
        end else if (state_reg == S_RDW) begin
            err_req.start = 1'b1;
        end

        seg_sum = {1'b0, rdata_reg.err} + {1'b0, err_rsp.err};
        seg_t   = seg_sum[ERR_W] ? '1 : seg_sum[ERR_W-1:0];

        eps_mult = 17'h10000 + 17'(eps_reg);
        thr_full = {phi_reg, 32'b0} + 81'(plo_reg);

        red  = lvl_err_reg[0] - lvl_err_reg[iidx];
        dsub = lvl_err_reg[0] - r_reg;

        st_end = {1'b0, rdata_reg.start} - (IDX_W+2)'(1);

        is_last_lvl = (32'(k_reg) == MAX_LEVELS - 1);
        next_idx    = (32'(item_idx_reg) + 1 >= MAX_ITEMS) ? '0 : item_idx_reg + IDX_W'(1);

        n_out  = (nb_reg == '0) ? 4'd1 : nb_reg;
        sel    = nb_reg - 4'd1 - out_idx_reg;
        st_ext = {16'b0, starts_reg[sel[ST_W-1:0]]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            max_levels_reg <= MAX_LEVELS_RST;
            eps_reg        <= EPS_RST;
            run_sum_reg    <= '0;
            run_sq_reg     <= '0;
            run_pts_reg    <= '0;
            item_idx_reg   <= '0;
            ovf_reg        <= 1'b0;
            nb_reg         <= '0;
            out_idx_reg    <= '0;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                lvl_err_reg[l] <= '0;
                thr_reg[l]     <= '1;
                thr_set_reg[l] <= 1'b0;
                fill_reg[l]    <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_LEVELS:   max_levels_reg <= cfg_wdata[3:0];
                    CFG_EPS_FRACTION: eps_reg        <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        value_reg   <= s_item.value;
                        weight_reg  <= s_item.weight;
                        final_reg   <= s_item.final_item;
                        cur_key_reg <= item_idx_reg;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= value_reg * $signed({1'b0, weight_reg});
                    vsq_reg   <= 32'(value_reg * value_reg);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    run_sum_reg <= run_sum_reg + SUM_W'(prod_reg);
                    run_sq_reg  <= run_sq_reg + SQ_W'(vsq_reg * weight_reg);
                    run_pts_reg <= run_pts_reg + PTS_W'(weight_reg);
                    k_reg       <= '0;
                    state_reg   <= S_LVL;
                end
                S_LVL: begin
                    walk_reg <= '0;
                    if (k_reg == '0) begin
                        state_reg <= S_EWAIT;
                    end else begin
                        best_e_reg     <= prev_err_reg;
                        best_start_reg <= {1'b0, cur_key_reg} + (IDX_W+1)'(1);
                        state_reg      <= (prev_fill_reg > FILL_W'(1)) ? S_RD : S_JUDGE;
                    end
                end
                S_EWAIT: begin
                    if (err_rsp.done) begin
                        best_e_reg     <= err_rsp.err;
                        best_start_reg <= '0;
                        state_reg      <= S_JUDGE;
                    end
                end
                S_RD:  state_reg <= S_RDW;
                S_RDW: state_reg <= S_SEG;
                S_SEG: begin
                    if (err_rsp.done) begin
                        // first strictly smaller error wins
                        if (seg_t < best_e_reg) begin
                            best_e_reg     <= seg_t;
                            best_start_reg <= {1'b0, rdata_reg.key} + (IDX_W+1)'(1);
                        end
                        walk_reg  <= walk_reg + FILL_W'(1);
                        state_reg <= (32'(walk_reg) + 2 < 32'(prev_fill_reg)) ? S_RD : S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    lvl_err_reg[kidx] <= best_e_reg;
                    accept_reg        <= 1'b1;
                    state_reg         <= thr_set_reg[kidx] ? S_THR0 : S_WR;
                end
                S_THR0: begin
                    plo_reg   <= thr_reg[kidx][31:0] * eps_mult;
                    state_reg <= S_THR1;
                end
                S_THR1: begin
                    phi_reg   <= thr_reg[kidx][63:32] * eps_mult;
                    state_reg <= S_THR2;
                end
                S_THR2: begin
                    accept_reg <= {1'b0, best_e_reg, 16'b0} > thr_full;
                    state_reg  <= S_WR;
                end
                S_WR: begin
                    if (accept_reg) begin
                        thr_reg[kidx]     <= best_e_reg;
                        thr_set_reg[kidx] <= 1'b1;
                    end
                    fill_reg[kidx] <= new_fill;
                    if (slot_ovf) ovf_reg <= 1'b1;
                    prev_err_reg  <= best_e_reg;
                    prev_fill_reg <= new_fill;
                    k_reg         <= k_reg + KCNT_W'(1);
                    if (!is_last_lvl) begin
                        state_reg <= S_LVL;
                    end else begin
                        item_idx_reg <= next_idx;
                        if (!final_reg) begin
                            state_reg <= S_IDLE;
                        end else if (lvl_err_reg[0] == '0) begin
                            best_cnt_reg <= '0;
                            drop_reg     <= '0;
                            nb_reg       <= '0;
                            out_idx_reg  <= '0;
                            state_reg    <= S_EMIT;
                        end else begin
                            i_reg        <= KCNT_W'(1);
                            best_cnt_reg <= 4'd2;
                            top_reg      <= '0;
                            nb_reg       <= '0;
                            out_idx_reg  <= '0;
                            state_reg    <= S_BEST;
                        end
                    end
                end
                S_BEST: begin
                    if (i_reg == KCNT_W'(1) || red > top_reg) begin
                        top_reg      <= red;
                        best_cnt_reg <= 4'(i_reg) + 4'd1;
                    end
                    i_reg <= i_reg + KCNT_W'(1);
                    if (32'(i_reg) + 1 >= 32'(lv)) state_reg <= S_DSET;
                end
                S_DSET: begin
                    lev_reg  <= KCNT_W'(best_cnt_reg - 4'd1);
                    end_reg  <= {2'b0, cur_key_reg};
                    r_reg    <= top_reg;
                    dcnt_reg <= '0;
                    if (top_reg >= lvl_err_reg[0]) begin
                        drop_reg  <= 17'h10000;
                        state_reg <= S_BTL;
                    end else begin
                        drop_reg  <= '0;
                        state_reg <= S_DROP;
                    end
                end
                S_DROP: begin
                    // one fraction bit a cycle
                    if (r_reg >= dsub) begin
                        r_reg    <= r_reg - dsub;
                        drop_reg <= {drop_reg[15:0], 1'b1};
                    end else begin
                        r_reg    <= r_reg << 1;
                        drop_reg <= {drop_reg[15:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 4'd1;
                    if (dcnt_reg == 4'd15) state_reg <= S_BTL;
                end
                S_BTL: begin
                    bt_fill_reg <= fill_reg[levidx];
                    walk_reg    <= '0;
                    state_reg   <= (fill_reg[levidx] == '0) ? S_EMIT : S_BTR;
                end
                S_BTR: state_reg <= S_BTC;
                S_BTC: begin
                    if ($signed({2'b0, rdata_reg.key}) == end_reg) begin
                        if ($signed({1'b0, rdata_reg.start}) <= end_reg
                            && nb_reg < 4'(LEVEL_CAP)) begin
                            starts_reg[nb_reg[ST_W-1:0]] <= rdata_reg.start;
                            nb_reg                       <= nb_reg + 4'd1;
                        end
                        end_reg <= $signed(st_end);
                        lev_reg <= lev_reg - KCNT_W'(1);
                        state_reg <= ($signed(st_end) < 0 || lev_reg == '0) ? S_EMIT : S_BTL;
                    end else begin
                        walk_reg  <= walk_reg + FILL_W'(1);
                        state_reg <= (32'(walk_reg) + 1 < 32'(bt_fill_reg)) ? S_BTR : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (m_ready) begin
                        out_idx_reg <= out_idx_reg + 4'd1;
                        if (out_idx_reg + 4'd1 == n_out) begin
                            // clear set state, configuration stays
                            run_sum_reg  <= '0;
                            run_sq_reg   <= '0;
                            run_pts_reg  <= '0;
                            item_idx_reg <= '0;
                            ovf_reg      <= 1'b0;
                            for (int l = 0; l < MAX_LEVELS; l++) begin
                                lvl_err_reg[l] <= '0;
                                thr_reg[l]     <= '1;
                                thr_set_reg[l] <= 1'b0;
                                fill_reg[l]    <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_EMIT);

    assign m_item.best_count    = best_cnt_reg;
    assign m_item.variance_drop = drop_reg;
    assign m_item.bucket_start  = (nb_reg == '0) ? 16'd0 : st_ext[15:0];
    assign m_item.start_valid   = (nb_reg != '0);
    assign m_item.list_overflow = ovf_reg;
    assign m_item.run_end       = (out_idx_reg + 4'd1 == n_out);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while results pending");
    a_run_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_item.run_end) |=> s_ready)
        else $error("not idle after last result beat");
    a_err_start: assert property (@(posedge aclk) disable iff (!aresetn)
        err_req.start |-> !err_rsp.busy) else $error("error unit started while busy");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg[0]) <= MAX_KEPT) else $error("level fill beyond list size");

endmodule
